FILE: rtl/awss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package awss_pkg;

    // Row counter width: a frame never exceeds 65535 + 2 * 127 rows.
    localparam int RW     = 17;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 40;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] REG_ORDER  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_RATIO  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_WIDTH  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_HEIGHT = 3'd3;
    localparam logic [CFG_AW-1:0] REG_EDGE   = 3'd4;
    localparam logic [CFG_AW-1:0] REG_PITCH  = 3'd5;

    // Stencil order codes.
    localparam logic [1:0] ORD_2 = 2'd0;
    localparam logic [1:0] ORD_4 = 2'd1;
    localparam logic [1:0] ORD_8 = 2'd2;

    // Laplacian coefficients in Q2.22, centre first.
    localparam logic signed [24:0] COEF_TAB [3][5] = '{
        '{-25'sd8388608,  25'sd4194304,  25'sd0,       25'sd0,      25'sd0},
        '{-25'sd10485760, 25'sd5592405, -25'sd349525,  25'sd0,      25'sd0},
        '{-25'sd11942116, 25'sd6710886, -25'sd838861,  25'sd106522, -25'sd7490}
    };

    // Per-item side information carried down the arithmetic pipeline.
    typedef struct packed {
        logic [9:0]  col;
        logic [15:0] row;
        logic        last;
    } t_ctrl;

endpackage

`default_nettype wire

FILE: rtl/awss_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module awss_ram #(
    parameter int W = 24,
    parameter int D = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic                 i_re,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_q;

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

FILE: rtl/awss_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One line cell: holds one row of samples, indexed by column. The value read
// out is handed on to the next cell and written there when the pipeline advances.
module awss_cell #(
    parameter int W = 24,
    parameter int D = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_re,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    output logic      [W-1:0]         o_q
);

    logic [W-1:0] w_ram_q;
    logic         r_byp;
    logic [W-1:0] r_bdata;

    awss_ram #(.W(W), .D(D)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_re    (i_re),
        .i_raddr (i_raddr),
        .o_rdata (w_ram_q)
    );

    // A read that hits the column being written in the same cycle takes the new value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (i_re) begin
            r_byp <= i_we && (i_waddr == i_raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_bdata <= i_wdata;
        end
    end

    assign o_q = r_byp ? r_bdata : w_ram_q;

endmodule

`default_nettype wire

FILE: rtl/awss_arith.sv
`timescale 1ns / 1ps
`default_nettype none

// Arithmetic pipeline: coefficient products, Laplacian rounding, gain and
// the final update with saturation. Every stage moves when i_adv is high.
module awss_arith
    import awss_pkg::*;
#(
    parameter int STENCIL_HALF = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_adv,
    input  wire logic               i_valid,
    input  wire t_ctrl              i_ctrl,
    input  wire logic signed [25:0] i_sum [STENCIL_HALF],
    input  wire logic signed [23:0] i_centre,
    input  wire logic signed [23:0] i_prev,
    input  wire logic        [15:0] i_vel,
    input  wire logic        [1:0]  i_ord,
    input  wire logic        [39:0] i_ratio,
    output logic                    o_valid,
    output t_ctrl                   o_ctrl,
    output logic signed [23:0]      o_field
);

    localparam int SH = STENCIL_HALF;

    logic               r2_v, r3_v, r4_v, r5_v, r6_v;
    t_ctrl              r2_ctrl, r3_ctrl, r4_ctrl, r5_ctrl, r6_ctrl;
    logic signed [25:0] r2_base, r3_base, r4_base, r5_base, r6_base;
    logic signed [25:0] r2_sum [SH];
    logic signed [23:0] r2_ctr;
    logic        [15:0] r2_vel;
    logic        [1:0]  r2_ord;
    logic signed [50:0] r3_p0;
    logic signed [50:0] r3_p [SH];
    logic        [31:0] r3_v2;
    logic signed [53:0] r4_lap;
    logic        [47:0] r4_gh;
    logic        [55:0] r4_gl;
    logic        [31:0] r5_mag;
    logic               r5_neg, r6_neg;
    logic        [47:0] r5_g;
    logic        [55:0] r6_a, r6_b;

    logic        [2:0]  w_half;
    logic signed [53:0] w_lap;
    logic signed [53:0] w_rnd;
    logic signed [31:0] w_l20;
    logic        [56:0] w_rem;
    logic        [49:0] w_q;
    logic signed [51:0] w_res;

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (i_adv) begin
            r2_v <= i_valid;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    // Reach of the selected order.
    always_comb begin
        case (r2_ord)
            ORD_2:   w_half = 3'd1;
            ORD_4:   w_half = 3'd2;
            default: w_half = 3'd4;
        endcase
    end

    // Sum of the coefficient products.
    always_comb begin
        w_lap = 54'(r3_p0);
        for (int k = 0; k < SH; k++) begin
            w_lap = w_lap + 54'(r3_p[k]);
        end
    end

    // Round to 20 fraction bits, half up.
    always_comb begin
        w_rnd = r4_lap + 54'sd2097152;
        w_l20 = 32'(w_rnd >>> 22);
    end

    // Payload stages.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            // Stage 2: window sums and base term.
            r2_ctrl <= i_ctrl;
            r2_sum  <= i_sum;
            r2_ctr  <= i_centre;
            r2_base <= (26'(i_centre) <<< 1) - 26'(i_prev);
            r2_vel  <= i_vel;
            r2_ord  <= i_ord;
            // Stage 3: one product per stencil arm, velocity squared.
            r3_ctrl <= r2_ctrl;
            r3_base <= r2_base;
            r3_p0   <= 51'(COEF_TAB[r2_ord][0]) * (51'(r2_ctr) <<< 1);
            for (int k = 0; k < SH; k++) begin
                if (3'(k + 1) <= w_half) begin
                    r3_p[k] <= 51'(COEF_TAB[r2_ord][k+1]) * 51'(r2_sum[k]);
                end else begin
                    r3_p[k] <= '0;
                end
            end
            r3_v2   <= 32'(r2_vel) * 32'(r2_vel);
            // Stage 4: Laplacian sum, partial gain products.
            r4_ctrl <= r3_ctrl;
            r4_base <= r3_base;
            r4_lap  <= w_lap;
            r4_gh   <= 48'(r3_v2) * 48'(i_ratio[39:24]);
            r4_gl   <= 56'(r3_v2) * 56'(i_ratio[23:0]);
            // Stage 5: rounded Laplacian magnitude, gain with 32 fraction bits.
            r5_ctrl <= r4_ctrl;
            r5_base <= r4_base;
            r5_neg  <= w_l20[31];
            r5_mag  <= w_l20[31] ? 32'(-w_l20) : 32'(w_l20);
            r5_g    <= 48'(r4_gh + 48'(r4_gl >> 24));
            // Stage 6: magnitude times gain in two halves.
            r6_ctrl <= r5_ctrl;
            r6_base <= r5_base;
            r6_neg  <= r5_neg;
            r6_a    <= 56'(r5_mag) * 56'(r5_g[47:24]);
            r6_b    <= 56'(r5_mag) * 56'(r5_g[23:0]);
        end
    end

    // Round the correction half away from zero, add and saturate.
    always_comb begin
        w_rem = 57'({r6_a[7:0], 24'd0}) + 57'(r6_b);
        w_q   = 50'(r6_a >> 8) + 50'(w_rem >> 32) + 50'(w_rem[31]);
        if (r6_neg) begin
            w_res = 52'(r6_base) - $signed({2'b00, w_q});
        end else begin
            w_res = 52'(r6_base) + $signed({2'b00, w_q});
        end
        if (w_res > 52'sd8388607) begin
            o_field = 24'sh7FFFFF;
        end else if (w_res < -52'sd8388608) begin
            o_field = -24'sd8388608;
        end else begin
            o_field = 24'(w_res);
        end
    end

    assign o_valid = r6_v;
    assign o_ctrl  = r6_ctrl;

endmodule

`default_nettype wire

FILE: rtl/acoustic_wave_stencil_step_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Payload (lowest bit up)                          | Handshake
// s_       | in  | tdata: field_prev 24, field_curr 24, velocity 16 | tvalid/tready
// m_       | out | tdata: field_next 24, point_col 10, point_row 16 | tvalid/tready
//          |     | tlast: last_point                                |
// cfg      | in  | index 3, data 40                                 | write enable
//
// One item is taken per cycle while s_tready is high; after acceptance its result
// passes the line-cell read and five arithmetic stages behind it, then enters the
// output register.
// The result for a point is computed when the point STENCIL_HALF rows below arrives.
// Reset is synchronous and clears control state only; the line memories are not
// swept, as rows outside the current frame are masked to zero.
// A two-entry output buffer keeps s_tready high while one result waits; the
// whole pipeline holds only when both entries are full.
module acoustic_wave_stencil_step_unit
    import awss_pkg::*;
#(
    parameter int MAX_ROW      = 1024,
    parameter int STENCIL_HALF = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [63:0]       i_s_tdata,   // field_prev, field_curr, velocity
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic      [55:0]       o_m_tdata,   // field_next, point_col, point_row, zero
    output logic                   o_m_tlast,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_AW-1:0] i_cfg_addr,
    input  wire logic [CFG_DW-1:0] i_cfg_wdata
);

    localparam int SH  = STENCIL_HALF;
    localparam int NC  = 2 * SH;
    localparam int CW  = $clog2(MAX_ROW);
    localparam int PW  = CW + 1;
    localparam int LAW = $clog2(SH * MAX_ROW);

    // Configuration.
    logic [1:0]    r_order;
    logic [39:0]   r_ratio;
    logic [10:0]   r_nx;
    logic [15:0]   r_ny;
    logic [6:0]    r_ne;
    logic [10:0]   r_pitch;

    // Position counters.
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [LAW-1:0] r_wp;

    // Stage 1.
    logic          r_v1;
    logic          r_emit1;
    t_ctrl         r_ctrl1;
    logic [CW-1:0] r_c1;
    logic [23:0]   r_cur1;
    logic [39:0]   r_pv1;
    logic [NC:0]   r_rv1;
    logic [NC:0]   r_cv1;
    logic [23:0]   r_hs [NC];

    // Output buffer.
    logic          r_o_v, r_sk_v;
    logic [55:0]   r_o_data, r_sk_data;
    logic          r_o_last, r_sk_last;

    logic          w_adv, w_acc, w_take, w_cfg_hit;
    logic [PW-1:0] w_pe;
    logic [RW-1:0] w_rows, w_frame, w_rc, w_endc;
    logic          w_emit, w_last;
    logic [RW-1:0] w_colx, w_rowx;
    logic [NC:0]   w_rv, w_cv;
    logic [LAW-1:0] w_la_raddr;
    logic [1:0]    w_ord;
    logic [23:0]   w_cq [NC];
    logic [39:0]   w_pq [SH];
    logic [23:0]   w_la_q;
    logic [23:0]   w_row [NC+1];
    logic [23:0]   w_hz [NC+1];
    logic signed [25:0] w_sum [SH];
    logic          w_ar_v;
    t_ctrl         w_ar_ctrl;
    logic signed [23:0] w_ar_field;
    logic [55:0]   w_ar_data;

    assign w_adv      = !r_sk_v;
    assign w_acc      = i_s_tvalid && w_adv;
    assign w_take     = r_o_v && i_m_tready;
    assign w_cfg_hit  = i_cfg_we && (i_cfg_addr <= REG_PITCH);
    assign o_s_tready = w_adv;

    // Effective pitch, frame geometry and the per-item decisions.
    always_comb begin
        logic signed [15:0] cci;
        logic signed [RW:0] rri;
        if (r_pitch == 11'd0) begin
            w_pe = PW'(1);
        end else if (32'(r_pitch) > MAX_ROW) begin
            w_pe = PW'(MAX_ROW);
        end else begin
            w_pe = PW'(r_pitch);
        end
        w_rows  = RW'(r_ny) + RW'(r_ne) + RW'(r_ne);
        w_frame = RW'(r_ny) + RW'(r_ne) + ((32'(r_ne) > SH) ? RW'(r_ne) : RW'(SH));
        w_rc    = r_row - RW'(SH);
        w_emit  = (32'(r_row) >= SH) && (w_rc >= RW'(r_ne))
                  && (w_rc < RW'(r_ne) + RW'(r_ny))
                  && (RW'(r_col) >= RW'(r_ne))
                  && (RW'(r_col) < RW'(r_ne) + RW'(r_nx));
        w_colx  = RW'(r_col) - RW'(r_ne);
        w_rowx  = w_rc - RW'(r_ne);
        w_endc  = (RW'(r_ne) + RW'(r_nx) < RW'(w_pe)) ? RW'(r_ne) + RW'(r_nx) : RW'(w_pe);
        w_last  = (w_rc == RW'(r_ne) + RW'(r_ny) - RW'(1))
                  && (RW'(r_col) + RW'(1) == w_endc);
        // Rows r - j that lie inside the padded grid.
        for (int j = 0; j <= NC; j++) begin
            rri     = $signed({1'b0, r_row}) - (RW+1)'(j);
            w_rv[j] = (rri >= 0) && (rri < $signed({1'b0, w_rows}));
        end
        // Columns c - SH .. c + SH that lie inside the stored row.
        for (int i = 0; i <= NC; i++) begin
            cci     = $signed(16'(r_col)) + 16'(i - SH);
            w_cv[i] = (cci >= 0) && (cci < $signed(16'(w_pe)));
        end
        w_la_raddr = r_wp - LAW'(SH * int'(w_pe) - SH);
    end

    // Order selector: codes above eighth order act as eighth, and orders
    // reaching past the window fall back to the widest that fits.
    always_comb begin
        if (r_order == ORD_2 || r_order == ORD_4) begin
            w_ord = r_order;
        end else begin
            w_ord = ORD_8;
        end
        if (w_ord == ORD_8 && SH < 4) begin
            w_ord = ORD_4;
        end
        if (w_ord == ORD_4 && SH < 2) begin
            w_ord = ORD_2;
        end
    end

    // Configuration writes and position counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= 2'd2;
            r_ratio <= '0;
            r_nx    <= 11'd1;
            r_ny    <= 16'd1;
            r_ne    <= 7'd4;
            r_pitch <= 11'd1;
            r_col   <= '0;
            r_row   <= '0;
            r_wp    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_ORDER:  r_order <= i_cfg_wdata[1:0];
                    REG_RATIO:  r_ratio <= i_cfg_wdata[39:0];
                    REG_WIDTH:  r_nx    <= i_cfg_wdata[10:0];
                    REG_HEIGHT: r_ny    <= i_cfg_wdata[15:0];
                    REG_EDGE:   r_ne    <= i_cfg_wdata[6:0];
                    REG_PITCH:  r_pitch <= i_cfg_wdata[10:0];
                    default: ;
                endcase
            end
            if (w_cfg_hit) begin
                r_col <= '0;
                r_row <= '0;
            end else if (w_acc) begin
                if (RW'(r_col) + RW'(1) >= RW'(w_pe)) begin
                    r_col <= '0;
                    r_row <= (r_row + RW'(1) >= w_frame) ? '0 : r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (w_acc) begin
                r_wp <= r_wp + LAW'(1);
            end
        end
    end

    // Stage 1 registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_emit1      <= w_emit;
            r_ctrl1.col  <= w_colx[9:0];
            r_ctrl1.row  <= w_rowx[15:0];
            r_ctrl1.last <= w_last;
            r_c1         <= r_col;
            r_cur1       <= i_s_tdata[47:24];
            r_pv1        <= {i_s_tdata[63:48], i_s_tdata[23:0]};
            r_rv1        <= w_rv;
            r_cv1        <= w_cv;
        end
    end

    // Chain of row cells for the current field: cell j holds row r - j - 1.
    for (genvar j = 0; j < NC; j++) begin : g_cur
        logic [23:0] w_wd;
        if (j == 0) begin : g_head
            assign w_wd = r_cur1;
        end else begin : g_link
            assign w_wd = w_cq[j-1];
        end
        awss_cell #(.W(24), .D(MAX_ROW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_re    (w_acc),
            .i_raddr (r_col),
            .i_we    (r_v1 && w_adv),
            .i_waddr (r_c1),
            .i_wdata (w_wd),
            .o_q     (w_cq[j])
        );
    end

    // Chain of row cells delaying previous field and velocity by STENCIL_HALF rows.
    for (genvar j = 0; j < SH; j++) begin : g_pv
        logic [39:0] w_wd;
        if (j == 0) begin : g_head
            assign w_wd = r_pv1;
        end else begin : g_link
            assign w_wd = w_pq[j-1];
        end
        awss_cell #(.W(40), .D(MAX_ROW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_re    (w_acc),
            .i_raddr (r_col),
            .i_we    (r_v1 && w_adv),
            .i_waddr (r_c1),
            .i_wdata (w_wd),
            .o_q     (w_pq[j])
        );
    end

    // Look-ahead line: the centre row STENCIL_HALF points ahead of the item.
    awss_ram #(.W(24), .D(2 ** LAW)) u_la_ram (
        .i_clk   (i_clk),
        .i_we    (w_acc),
        .i_waddr (r_wp),
        .i_wdata (i_s_tdata[47:24]),
        .i_re    (w_acc),
        .i_raddr (w_la_raddr),
        .o_rdata (w_la_q)
    );

    // Horizontal window shift register.
    always_ff @(posedge i_clk) begin
        if (r_v1 && w_adv) begin
            r_hs[0] <= w_la_q;
            for (int i = 1; i < NC; i++) begin
                r_hs[i] <= r_hs[i-1];
            end
        end
    end

    // Vertical taps by row offset and horizontal taps by column offset.
    always_comb begin
        w_row[0]  = r_cur1;
        w_hz[NC]  = w_la_q;
        for (int j = 1; j <= NC; j++) begin
            w_row[j] = w_cq[j-1];
        end
        for (int i = 0; i < NC; i++) begin
            w_hz[i] = r_hs[NC-1-i];
        end
    end

    // Four-point sums for every arm length, off-grid points masked to zero.
    always_comb begin
        for (int k = 1; k <= SH; k++) begin
            w_sum[k-1] = (r_rv1[SH+k] ? 26'($signed(w_row[SH+k])) : 26'sd0)
                       + (r_rv1[SH-k] ? 26'($signed(w_row[SH-k])) : 26'sd0)
                       + (r_cv1[SH-k] ? 26'($signed(w_hz[SH-k]))  : 26'sd0)
                       + (r_cv1[SH+k] ? 26'($signed(w_hz[SH+k]))  : 26'sd0);
        end
    end

    awss_arith #(.STENCIL_HALF(SH)) u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_valid  (r_v1 && r_emit1),
        .i_ctrl   (r_ctrl1),
        .i_sum    (w_sum),
        .i_centre ($signed(w_cq[SH-1])),
        .i_prev   ($signed(w_pq[SH-1][23:0])),
        .i_vel    (w_pq[SH-1][39:24]),
        .i_ord    (w_ord),
        .i_ratio  (r_ratio),
        .o_valid  (w_ar_v),
        .o_ctrl   (w_ar_ctrl),
        .o_field  (w_ar_field)
    );

    assign w_ar_data = {6'd0, w_ar_ctrl.row, w_ar_ctrl.col, w_ar_field};

    // Output register with one skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v  <= 1'b0;
            r_sk_v <= 1'b0;
        end else if (r_sk_v) begin
            if (w_take) begin
                r_o_data <= r_sk_data;
                r_o_last <= r_sk_last;
                r_sk_v   <= 1'b0;
            end
        end else if (w_ar_v) begin
            if (!r_o_v || w_take) begin
                r_o_data <= w_ar_data;
                r_o_last <= w_ar_ctrl.last;
                r_o_v    <= 1'b1;
            end else begin
                r_sk_data <= w_ar_data;
                r_sk_last <= w_ar_ctrl.last;
                r_sk_v    <= 1'b1;
            end
        end else if (w_take) begin
            r_o_v <= 1'b0;
        end
    end

    assign o_m_tvalid = r_o_v;
    assign o_m_tdata  = r_o_data;
    assign o_m_tlast  = r_o_last;

    // The skid entry is only ever filled behind a waiting result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_v |-> r_o_v)
        else $error("skid entry holds an item while the output register is empty");

    // Every accepted item reaches the line-cell stage in the next cycle.
    a_accept_to_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_v1)
        else $error("accepted item missing from the line-cell stage");

    // The column counter stays inside the stored row.
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PW'(r_col) < w_pe)
        else $error("column counter beyond the row pitch");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import awss_pkg::*;

    localparam int MAX_ROW = 1024;
    localparam int HALF    = 4;
    localparam int WIN     = 2 * HALF;

    // Data patterns for a frame.
    localparam int PAT_RANDOM  = 0;
    localparam int PAT_EXTREME = 1;
    localparam int PAT_SMALL   = 2;

    typedef struct {
        logic [23:0] next;
        logic [9:0]  col;
        logic [15:0] row;
        logic        last;
    } t_point;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [63:0]       i_s_tdata = '0;   // field_prev, field_curr, velocity
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [55:0]       o_m_tdata;        // field_next, point_col, point_row, zero
    logic              o_m_tlast;
    logic              i_cfg_we = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr = '0;
    logic [CFG_DW-1:0] i_cfg_wdata = '0;

    acoustic_wave_stencil_step_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .o_m_tlast(o_m_tlast),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata)
    );

    // Clock with a 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow copy of the registers, line stores and counters.
    bit [1:0]  cfg_order;
    bit [39:0] cfg_ratio;
    bit [10:0] cfg_width;
    bit [15:0] cfg_height;
    bit [6:0]  cfg_edge;
    bit [10:0] cfg_pitch;
    logic signed [23:0] row_window [WIN*MAX_ROW];
    logic signed [23:0] prev_dly [HALF*MAX_ROW];
    bit [15:0]          vel_dly [HALF*MAX_ROW];
    int col_pos;
    int row_pos;

    t_point pending_points [$];
    int     mismatches;
    int     items_sent;
    int     points_checked;
    int     frames_run;
    bit     idle_on;
    int     hold_request;

    function automatic int eff_pitch();
        if (cfg_pitch == 0) return 1;
        if (cfg_pitch > MAX_ROW) return MAX_ROW;
        return cfg_pitch;
    endfunction

    function automatic int frame_rows();
        return cfg_height + cfg_edge + (cfg_edge > HALF ? cfg_edge : HALF);
    endfunction

    function automatic longint grid_value(longint rr, longint cc, longint r,
                                          logic signed [23:0] curin,
                                          longint rows, longint pitch);
        if (rr < 0 || rr >= rows || cc < 0 || cc >= pitch) return 0;
        if (rr == r) return longint'(curin);
        return longint'(row_window[(rr % WIN) * MAX_ROW + cc]);
    endfunction

    // Work out the updated field for the point that this item completes.
    function automatic void predict_point(logic signed [23:0] prev_in,
                                          logic signed [23:0] curr_in,
                                          bit [15:0] vel_in);
        int pitch, ne, nx, ny, r, c, dslot, endc, ord, reach;
        longint rows, rc, lap, lap20, base, res, s;
        bit [63:0] vel64, v2, g, mag, a, b, rem, q;
        t_point p;
        pitch = eff_pitch();
        ne = cfg_edge;
        nx = cfg_width;
        ny = cfg_height;
        r = row_pos;
        c = col_pos;
        rows = ny + 2 * ne;
        dslot = (r % HALF) * MAX_ROW + c;
        if (r >= HALF) begin
            rc = r - HALF;
            if (rc >= ne && rc < ne + ny && c >= ne && c < ne + nx) begin
                ord = (cfg_order == 2'd3) ? ORD_8 : cfg_order;
                reach = (ord == ORD_2) ? 1 : ((ord == ORD_4) ? 2 : 4);
                endc = (ne + nx < pitch) ? ne + nx : pitch;
                lap = longint'(COEF_TAB[ord][0]) * 2 * grid_value(rc, c, r, curr_in, rows, pitch);
                for (int k = 1; k <= reach; k++) begin
                    s = grid_value(rc - k, c, r, curr_in, rows, pitch)
                      + grid_value(rc + k, c, r, curr_in, rows, pitch)
                      + grid_value(rc, c - k, r, curr_in, rows, pitch)
                      + grid_value(rc, c + k, r, curr_in, rows, pitch);
                    lap += longint'(COEF_TAB[ord][k]) * s;
                end
                lap20 = (lap + 64'sd2097152) >>> 22;

                // Gain with 32 fraction bits, then scaled and rounded away from zero.
                vel64 = vel_dly[dslot];
                v2 = vel64 * vel64;
                g = v2 * (cfg_ratio >> 24) + ((v2 * (cfg_ratio & 40'hFF_FFFF)) >> 24);
                mag = (lap20 < 0) ? -lap20 : lap20;
                a = mag * (g >> 24);
                b = mag * (g & 64'hFF_FFFF);
                rem = ((a & 64'hFF) << 24) + b;
                q = (a >> 8) + (rem >> 32) + ((rem >> 31) & 64'd1);

                base = 2 * longint'(row_window[(rc % WIN) * MAX_ROW + c])
                     - longint'(prev_dly[dslot]);
                res = (lap20 < 0) ? base - $signed(q) : base + $signed(q);
                if (res > 64'sd8388607) res = 8388607;
                if (res < -64'sd8388608) res = -8388608;

                p.next = res[23:0];
                p.col  = 10'(c - ne);
                p.row  = 16'(rc - ne);
                p.last = (rc == ne + ny - 1 && c + 1 == endc);
                pending_points.push_back(p);
            end
        end
        row_window[(r % WIN) * MAX_ROW + c] = curr_in;
        prev_dly[dslot] = prev_in;
        vel_dly[dslot] = vel_in;
        c++;
        if (c >= pitch) begin
            c = 0;
            r++;
            if (r >= frame_rows()) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Result checker: compares each accepted item with the oldest expectation.
    always @(posedge i_clk) begin
        t_point p;
        if (o_m_tvalid && i_m_tready) begin
            if (pending_points.size() == 0) begin
                report_mismatch("unexpected result", o_m_tdata[31:0], 32'd0);
            end else begin
                p = pending_points.pop_front();
                if (o_m_tdata[23:0] !== p.next)  report_mismatch("field_next", o_m_tdata[23:0], p.next);
                if (o_m_tdata[33:24] !== p.col)  report_mismatch("point_col", o_m_tdata[33:24], p.col);
                if (o_m_tdata[49:34] !== p.row)  report_mismatch("point_row", o_m_tdata[49:34], p.row);
                if (o_m_tlast !== p.last)        report_mismatch("last_point", o_m_tlast, p.last);
                points_checked++;
            end
        end
    end

    // Receiver: random short stalls, plus a long hold when a test asks for one.
    int hold_left = 0;
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 5);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Offer one item and return at the edge where it is taken; valid stays high.
    task automatic send_item(input logic [23:0] prev_in, input logic [23:0] curr_in,
                             input logic [15:0] vel_in);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {vel_in, curr_in, prev_in};
        @(negedge i_clk);
        while (!o_s_tready) @(negedge i_clk);
        @(posedge i_clk);
        predict_point(prev_in, curr_in, vel_in);
        items_sent++;
    endtask

    // Lower valid and wait until every expected result has come, plus latency.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // One register write; the caller lowers the write enable after the last one.
    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            REG_ORDER:  cfg_order  = val[1:0];
            REG_RATIO:  cfg_ratio  = val[39:0];
            REG_WIDTH:  cfg_width  = val[10:0];
            REG_HEIGHT: cfg_height = val[15:0];
            REG_EDGE:   cfg_edge   = val[6:0];
            REG_PITCH:  cfg_pitch  = val[10:0];
            default: ;
        endcase
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic configure(input int ord, input logic [39:0] ratio, input int w,
                             input int h, input int e, input int p);
        drain();
        write_reg(REG_ORDER, CFG_DW'(ord));
        write_reg(REG_RATIO, ratio);
        write_reg(REG_WIDTH, CFG_DW'(w));
        write_reg(REG_HEIGHT, CFG_DW'(h));
        write_reg(REG_EDGE, CFG_DW'(e));
        write_reg(REG_PITCH, CFG_DW'(p));
        i_cfg_we <= 1'b0;
    endtask

    // Stream one frame (or its first max_items items) with the chosen pattern.
    task automatic run_frame(input int pattern, input int max_items);
        int n;
        logic [23:0] pv, cv;
        logic [15:0] vv;
        n = frame_rows() * eff_pitch();
        if (max_items > 0 && n > max_items) n = max_items;
        for (int i = 0; i < n; i++) begin
            case (pattern)
                PAT_EXTREME: begin
                    pv = (i % 3 == 0) ? 24'h7F_FFFF : ((i % 3 == 1) ? 24'h80_0000 : 24'h0);
                    cv = (i % 4 < 2) ? 24'h7F_FFFF : 24'h80_0000;
                    vv = (i % 2 == 0) ? 16'hFFFF : 16'h0;
                end
                PAT_SMALL: begin
                    pv = 24'($signed($urandom_range(0, 8191)) - 4096);
                    cv = 24'($signed($urandom_range(0, 8191)) - 4096);
                    vv = 16'($urandom_range(0, 255));
                end
                default: begin
                    pv = 24'($urandom);
                    cv = 24'($urandom);
                    vv = 16'($urandom);
                end
            endcase
            send_item(pv, cv, vv);
        end
        frames_run++;
    endtask

    task automatic test_reset_values();
        // Registers as left by reset: no interior column falls inside the pitch.
        run_frame(PAT_RANDOM, 0);
        drain();
    endtask

    task automatic test_field_extremes();
        configure(ORD_8, 40'hFF_FFFF_FFFF, 3, 3, 1, 5);
        run_frame(PAT_EXTREME, 0);
        configure(ORD_4, 40'h0, 2, 2, 2, 6);
        run_frame(PAT_EXTREME, 0);
    endtask

    task automatic test_orders();
        for (int o = 0; o < 4; o++) begin
            configure(o, {8'($urandom_range(0, 255)), $urandom}, 3, 2, 1, 6);
            run_frame(PAT_SMALL, 0);
        end
    endtask

    task automatic test_odd_geometry();
        // Pitch zero, pitch clamped to the maximum (first items only), wide
        // interior cut by the pitch.
        configure(ORD_2, 40'h10_0000_0000, 1, 1, 1, 0);
        run_frame(PAT_RANDOM, 0);
        configure(ORD_8, 40'h1_0000_0000, 1024, 1, 1, 2047);
        run_frame(PAT_SMALL, 60);
        configure(ORD_4, 40'h2_0000_0000, 6, 2, 1, 5);
        run_frame(PAT_RANDOM, 0);
        // Zero edge, zero width, zero height.
        configure(ORD_8, 40'h3_0000_0000, 3, 2, 0, 3);
        run_frame(PAT_RANDOM, 0);
        configure(ORD_8, 40'h3_0000_0000, 0, 2, 1, 4);
        run_frame(PAT_RANDOM, 0);
        configure(ORD_2, 40'h3_0000_0000, 2, 0, 1, 4);
        run_frame(PAT_RANDOM, 0);
        // Edge wider than the stencil reach, and the tallest grid cut short
        // by a register write.
        configure(ORD_8, 40'h1_0000_0000, 1, 1, 5, 11);
        run_frame(PAT_SMALL, 0);
        configure(ORD_4, 40'h4_0000_0000, 1, 65535, 1, 3);
        run_frame(PAT_SMALL, 60);
    endtask

    task automatic test_backpressure();
        configure(ORD_8, 40'h8_0000_0000, 8, 10, 2, 12);
        // The receiver holds off while the sender keeps offering items.
        hold_request = 300;
        run_frame(PAT_SMALL, 80);
        // The sender pauses until every expected result has come, then resumes.
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_points.size() != 0) @(posedge i_clk);
        for (int i = 0; i < 40; i++) send_item(24'($urandom), 24'($urandom), 16'($urandom));
        drain();
    endtask

    task automatic test_random_frames();
        int target;
        int w, e, p;
        target = items_sent + 300;
        while (items_sent < target) begin
            if (items_sent > target - 120) idle_on = 1'b0;
            w = $urandom_range(1, 8);
            e = $urandom_range(0, 5);
            p = ($urandom_range(0, 4) == 0) ? $urandom_range(1, w + 2 * e + 1)
                                            : w + 2 * e + $urandom_range(0, 2);
            configure($urandom_range(0, 3), {8'($urandom_range(0, 31)), $urandom}, w,
                      $urandom_range(1, 6), e, p);
            run_frame($urandom_range(0, 1) ? PAT_SMALL : PAT_RANDOM, 0);
        end
        drain();
    endtask

    // Run limit.
    initial begin
        #100ms;
        $display("acoustic_wave_stencil_step_unit test failed");
        $finish;
    end

    initial begin
        cfg_order = 2'd2;
        cfg_ratio = '0;
        cfg_width = 11'd1;
        cfg_height = 16'd1;
        cfg_edge = 7'd4;
        cfg_pitch = 11'd1;
        col_pos = 0;
        row_pos = 0;
        idle_on = 1'b1;
        hold_request = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_field_extremes();
        test_orders();
        test_odd_geometry();
        test_backpressure();
        test_random_frames();

        repeat (20) @(posedge i_clk);
        if (pending_points.size() != 0)
            report_mismatch("results never arrived", pending_points.size(), 0);
        $display("Covered %0d frames over all stencil orders and edge geometries,", frames_run);
        $display("%0d items sent, %0d results checked, with stalls on both sides.",
                 items_sent, points_checked);
        if (mismatches == 0) begin
            $display("acoustic_wave_stencil_step_unit test passed");
        end else begin
            $display("acoustic_wave_stencil_step_unit test failed");
        end
        $finish;
    end

endmodule
